### hdl/biou_pkg.sv
// Package for the box overlap cost block: default widths and queue sizing.
// Every file of the block but biou_if.sv imports it, and it depends on nothing.
package biou_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   // The queue depth must be a power of two so that its pointers wrap on their own.
   localparam int QUEUE_DEPTH    = 4;

endpackage

### hdl/biou_if.sv
// Channel interfaces for the box overlap cost block: the pair request and the cost response.
// Both carry valid, ready and the payload and depend on nothing else.
interface biou_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] track_left;
   logic signed [COORD_BITS-1:0] track_top;
   logic        [COORD_BITS-1:0] track_width;
   logic        [COORD_BITS-1:0] track_height;
   logic signed [COORD_BITS-1:0] det_left;
   logic signed [COORD_BITS-1:0] det_top;
   logic        [COORD_BITS-1:0] det_width;
   logic        [COORD_BITS-1:0] det_height;
   logic        [7:0]            frames_stale;

   modport source (
      output valid, track_left, track_top, track_width, track_height,
             det_left, det_top, det_width, det_height, frames_stale,
      input  ready
   );
   modport sink (
      input  valid, track_left, track_top, track_width, track_height,
             det_left, det_top, det_width, det_height, frames_stale,
      output ready
   );
endinterface

interface biou_rsp_if #(
   parameter int FRAC_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS:0]   cost;
   logic                 gated;

   modport source (
      output valid, cost, gated,
      input  ready
   );
   modport sink (
      input  valid, cost, gated,
      output ready
   );
endinterface

### hdl/box_iou_cost.sv
// Top level of the box overlap cost block: front part, queue and back part.
// Uses biou_pkg, the channel interfaces, biou_front, biou_queue and biou_back.
//
//   channel   direction  payload
//   req_chan  in         two boxes (left, top, width, height) and frames_stale
//   rsp_chan  out        cost in unsigned Q1.FRAC_BITS and the gated flag
//
// One pair is accepted per cycle and one cost leaves per cycle while the response side is ready.
// A pair's cost passes through the queue, the multiply and union stages, the divider and the
// output register; the divider produces one quotient bit in each of FRAC_BITS + 1 stages.
// Reset is synchronous and clears the queue and all stage valid bits.
// A stalled response holds the whole back pipeline; the queue then absorbs
// up to QUEUE_DEPTH more pairs before the request side is stalled.
module box_iou_cost
   import biou_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   biou_req_if.sink    req_chan,
   biou_rsp_if.source  rsp_chan
);

   localparam int QW = 6 * COORD_BITS + 1;

   logic          push_valid;
   logic          push_ready;
   logic [QW-1:0] push_data;
   logic          pop_valid;
   logic          pop_ready;
   logic [QW-1:0] pop_data;

   biou_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_chan   (req_chan),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   biou_queue #(
      .DATA_BITS (QW),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   biou_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

### hdl/biou_front.sv
// Front part: accepts a box pair, flags stale tracks and measures the overlap lengths.
// Uses biou_pkg and the request interface; feeds the queue.
module biou_front
   import biou_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   biou_req_if.sink                req_chan,
   input  logic                    push_ready,
   output logic                    push_valid,
   output logic [6*COORD_BITS:0]   push_data
);

   localparam int EW = COORD_BITS + 2;

   function automatic logic [COORD_BITS-1:0] overlap_len(
      input logic [COORD_BITS-1:0] a0,
      input logic [COORD_BITS-1:0] aw,
      input logic [COORD_BITS-1:0] b0,
      input logic [COORD_BITS-1:0] bw
   );
      logic signed [EW-1:0] a_lo;
      logic signed [EW-1:0] a_hi;
      logic signed [EW-1:0] b_lo;
      logic signed [EW-1:0] b_hi;
      logic signed [EW-1:0] lo;
      logic signed [EW-1:0] hi;
      logic signed [EW-1:0] diff;
      a_lo = $signed({{2{a0[COORD_BITS-1]}}, a0});
      b_lo = $signed({{2{b0[COORD_BITS-1]}}, b0});
      a_hi = a_lo + $signed({2'b00, aw});
      b_hi = b_lo + $signed({2'b00, bw});
      lo   = (a_lo > b_lo) ? a_lo : b_lo;
      hi   = (a_hi < b_hi) ? a_hi : b_hi;
      diff = hi - lo;
      overlap_len = (hi > lo) ? diff[COORD_BITS-1:0] : '0;
   endfunction

   logic                  gated;
   logic [COORD_BITS-1:0] inter_w;
   logic [COORD_BITS-1:0] inter_h;

   always_comb begin
      gated   = (req_chan.frames_stale > 8'd1);
      inter_w = overlap_len(req_chan.track_left, req_chan.track_width,
                            req_chan.det_left, req_chan.det_width);
      inter_h = overlap_len(req_chan.track_top, req_chan.track_height,
                            req_chan.det_top, req_chan.det_height);
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;
   assign push_data      = {gated, req_chan.track_width, req_chan.track_height,
                            req_chan.det_width, req_chan.det_height, inter_w, inter_h};

endmodule

### hdl/biou_queue.sv
// Short first-in first-out queue between the front and back parts.
// Uses biou_pkg for its depth; the payload width comes from the instantiating module.
module biou_queue
   import biou_pkg::*;
#(
   parameter int DATA_BITS = 97,
   parameter int DEPTH     = QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output logic [DATA_BITS-1:0] pop_data
);

   localparam int AW = $clog2(DEPTH);

   logic [DATA_BITS-1:0] entry_ff [DEPTH];
   logic [AW-1:0]        wr_ptr_ff;
   logic [AW-1:0]        wr_ptr_in;
   logic [AW-1:0]        rd_ptr_ff;
   logic [AW-1:0]        rd_ptr_in;
   logic [AW:0]          count_ff;
   logic [AW:0]          count_in;
   logic                 push;
   logic                 pop;

   assign push_ready = (count_ff != (AW+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/biou_back.sv
// Back part: areas, union, a pipelined restoring divider and the cost output register.
// Uses biou_pkg and the response interface; is fed by the queue.
module biou_back
   import biou_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  logic [6*COORD_BITS:0] pop_data,
   biou_rsp_if.source            rsp_chan
);

   localparam int C  = COORD_BITS;
   localparam int AB = 2 * C;
   localparam int UB = 2 * C + 1;
   localparam int NS = FRAC_BITS + 1;

   localparam logic [FRAC_BITS:0] COST_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   logic          advance;

   // Multiply stage.
   logic          m_vld_ff;
   logic          m_gated_ff;
   logic [AB-1:0] m_inter_ff;
   logic [AB-1:0] m_area_t_ff;
   logic [AB-1:0] m_area_d_ff;

   // Union stage.
   logic          u_vld_ff;
   logic          u_force_ff;
   logic          u_gated_ff;
   logic [AB-1:0] u_num_ff;
   logic [UB-1:0] u_den_ff;
   logic [UB-1:0] u_den_in;

   // Divider stages, one quotient bit each.
   logic               d_vld_ff   [NS];
   logic               d_force_ff [NS];
   logic               d_gated_ff [NS];
   logic [UB-1:0]      d_rem_ff   [NS];
   logic [UB-1:0]      d_den_ff   [NS];
   logic [FRAC_BITS:0] d_quo_ff   [NS];
   logic [UB-1:0]      d_rem_in   [NS];
   logic [FRAC_BITS:0] d_quo_in   [NS];

   // Output register.
   logic               o_vld_ff;
   logic               o_gated_ff;
   logic [FRAC_BITS:0] o_cost_ff;
   logic [FRAC_BITS:0] o_cost_in;

   logic [C-1:0] q_track_w;
   logic [C-1:0] q_track_h;
   logic [C-1:0] q_det_w;
   logic [C-1:0] q_det_h;
   logic [C-1:0] q_inter_w;
   logic [C-1:0] q_inter_h;
   logic         q_gated;

   assign advance   = !o_vld_ff || rsp_chan.ready;
   assign pop_ready = advance;

   assign q_gated   = pop_data[6*C];
   assign q_track_w = pop_data[6*C-1:5*C];
   assign q_track_h = pop_data[5*C-1:4*C];
   assign q_det_w   = pop_data[4*C-1:3*C];
   assign q_det_h   = pop_data[3*C-1:2*C];
   assign q_inter_w = pop_data[2*C-1:C];
   assign q_inter_h = pop_data[C-1:0];

   always_comb begin
      logic [UB:0] shifted;
      logic [UB:0] den_ext;
      logic [UB:0] diff;
      u_den_in = UB'(m_area_t_ff) + UB'(m_area_d_ff) - UB'(m_inter_ff);

      if (UB'(u_num_ff) >= u_den_ff) begin
         d_rem_in[0] = UB'(u_num_ff) - u_den_ff;
         d_quo_in[0] = (FRAC_BITS+1)'(1);
      end else begin
         d_rem_in[0] = UB'(u_num_ff);
         d_quo_in[0] = '0;
      end

      for (int k = 1; k < NS; k++) begin
         shifted = {d_rem_ff[k-1], 1'b0};
         den_ext = {1'b0, d_den_ff[k-1]};
         diff    = shifted - den_ext;
         if (shifted >= den_ext) begin
            d_rem_in[k] = diff[UB-1:0];
            d_quo_in[k] = {d_quo_ff[k-1][FRAC_BITS-1:0], 1'b1};
         end else begin
            d_rem_in[k] = shifted[UB-1:0];
            d_quo_in[k] = {d_quo_ff[k-1][FRAC_BITS-1:0], 1'b0};
         end
      end

      if (d_force_ff[NS-1]) begin
         o_cost_in = COST_ONE;
      end else begin
         o_cost_in = COST_ONE - d_quo_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         u_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
         for (int k = 0; k < NS; k++) begin
            d_vld_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         m_vld_ff    <= pop_valid;
         u_vld_ff    <= m_vld_ff;
         d_vld_ff[0] <= u_vld_ff;
         for (int k = 1; k < NS; k++) begin
            d_vld_ff[k] <= d_vld_ff[k-1];
         end
         o_vld_ff    <= d_vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_gated_ff  <= q_gated;
         m_inter_ff  <= q_inter_w * q_inter_h;
         m_area_t_ff <= q_track_w * q_track_h;
         m_area_d_ff <= q_det_w * q_det_h;

         u_gated_ff  <= m_gated_ff;
         u_force_ff  <= m_gated_ff || (u_den_in == '0);
         u_num_ff    <= m_inter_ff;
         u_den_ff    <= u_den_in;

         d_gated_ff[0] <= u_gated_ff;
         d_force_ff[0] <= u_force_ff;
         d_den_ff[0]   <= u_den_ff;
         d_rem_ff[0]   <= d_rem_in[0];
         d_quo_ff[0]   <= d_quo_in[0];
         for (int k = 1; k < NS; k++) begin
            d_gated_ff[k] <= d_gated_ff[k-1];
            d_force_ff[k] <= d_force_ff[k-1];
            d_den_ff[k]   <= d_den_ff[k-1];
            d_rem_ff[k]   <= d_rem_in[k];
            d_quo_ff[k]   <= d_quo_in[k];
         end

         o_gated_ff <= d_gated_ff[NS-1];
         o_cost_ff  <= o_cost_in;
      end
   end

   assign rsp_chan.valid = o_vld_ff;
   assign rsp_chan.cost  = o_cost_ff;
   assign rsp_chan.gated = o_gated_ff;

endmodule

### sim/box_iou_cost_tb.sv
// Self-checking testbench for box_iou_cost: corner-case and random box pairs are scored
// against a built-in integer IoU cost predictor, with random sender bursts and receiver stalls.
// Depends on biou_pkg, the channel interfaces in biou_if.sv and the box_iou_cost RTL.
module box_iou_cost_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import biou_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam longint COST_ONE = longint'(1) << FB;
   localparam int LATENCY = FB + 5;
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      logic signed [CB-1:0] track_left;
      logic signed [CB-1:0] track_top;
      logic        [CB-1:0] track_width;
      logic        [CB-1:0] track_height;
      logic signed [CB-1:0] det_left;
      logic signed [CB-1:0] det_top;
      logic        [CB-1:0] det_width;
      logic        [CB-1:0] det_height;
      logic        [7:0]    frames_stale;
   } pair_type;

   typedef struct {
      logic [FB:0] cost;
      logic        gated;
   } cost_type;

   logic clock;
   logic reset;

   biou_req_if #(.COORD_BITS(CB)) req_chan ();
   biou_rsp_if #(.FRAC_BITS(FB))  rsp_chan ();

   box_iou_cost #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   cost_type pending_costs[$];
   int       mismatch_count = 0;
   int       burst_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("box_iou_cost verification failed");
      $finish;
   end

   function automatic longint span_overlap(longint a0, longint a1, longint b0, longint b1);
      longint lo;
      longint hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a1 < b1) ? a1 : b1;
      return (hi > lo) ? hi - lo : 0;
   endfunction

   function automatic cost_type predict_cost(pair_type p);
      longint tl, tt, tw, th, dl, dt, dw, dh;
      longint inter, union_area;
      cost_type r;
      r.cost  = (FB+1)'(COST_ONE);
      r.gated = (p.frames_stale > 8'd1);
      if (r.gated) return r;
      tl = p.track_left;
      tt = p.track_top;
      tw = p.track_width;
      th = p.track_height;
      dl = p.det_left;
      dt = p.det_top;
      dw = p.det_width;
      dh = p.det_height;
      inter = span_overlap(tl, tl + tw, dl, dl + dw) * span_overlap(tt, tt + th, dt, dt + dh);
      union_area = tw * th + dw * dh - inter;
      if (union_area != 0)
         r.cost = (FB+1)'(COST_ONE - ((inter << FB) / union_area));
      return r;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      p.track_left   = CB'($urandom);
      p.track_top    = CB'($urandom);
      p.track_width  = CB'($urandom);
      p.track_height = CB'($urandom);
      p.det_left     = CB'($urandom);
      p.det_top      = CB'($urandom);
      p.det_width    = CB'($urandom);
      p.det_height   = CB'($urandom);
      p.frames_stale = 8'($urandom);
      return p;
   endfunction

   function automatic pair_type box_pair(int tl, int tt, int tw, int th,
                                         int dl, int dt, int dw, int dh, int stale);
      pair_type p;
      p.track_left   = CB'(tl);
      p.track_top    = CB'(tt);
      p.track_width  = CB'(tw);
      p.track_height = CB'(th);
      p.det_left     = CB'(dl);
      p.det_top      = CB'(dt);
      p.det_width    = CB'(dw);
      p.det_height   = CB'(dh);
      p.frames_stale = 8'(stale);
      return p;
   endfunction

   task automatic drive_payload(pair_type p);
      req_chan.track_left   <= p.track_left;
      req_chan.track_top    <= p.track_top;
      req_chan.track_width  <= p.track_width;
      req_chan.track_height <= p.track_height;
      req_chan.det_left     <= p.det_left;
      req_chan.det_top      <= p.det_top;
      req_chan.det_width    <= p.det_width;
      req_chan.det_height   <= p.det_height;
      req_chan.frames_stale <= p.frames_stale;
   endtask

   task automatic report_mismatch(string what, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   // The pair is recorded at the edge of its transfer; a burst ends with an idle gap.
   task automatic send_pair(pair_type p);
      req_chan.valid <= 1'b1;
      drive_payload(p);
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      pending_costs = {pending_costs, predict_cost(p)};
      burst_left--;
      if (burst_left <= 0) begin
         req_chan.valid <= 1'b0;
         drive_payload(random_pair());
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
      end
   endtask

   initial begin : rsp_check
      cost_type    want;
      logic [15:0] ready_pattern;
      logic [3:0]  ready_phase;
      ready_pattern = 16'hFFFF;
      ready_phase   = 4'd0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (pending_costs.size() == 0) begin
               report_mismatch("unexpected cost", -1, rsp_chan.cost);
            end else begin
               want = pending_costs.pop_front();
               if (rsp_chan.cost !== want.cost)
                  report_mismatch("cost", want.cost, rsp_chan.cost);
               if (rsp_chan.gated !== want.gated)
                  report_mismatch("gated", want.gated, rsp_chan.gated);
            end
         end
         rsp_chan.ready <= ready_pattern[ready_phase];
         ready_phase = ready_phase + 4'd1;
         if (ready_phase == 4'd0 && $urandom_range(0, 3) == 0)
            ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                        : (16'($urandom) | 16'h0001);
      end
   end

   task automatic test_corner_boxes();
      send_pair(box_pair(10, 20, 30, 40, 10, 20, 30, 40, 0));
      send_pair(box_pair(10, 20, 30, 40, 10, 20, 30, 40, 1));
      send_pair(box_pair(5, 5, 0, 0, 5, 5, 0, 0, 0));
      send_pair(box_pair(0, 0, 0, 100, 0, 0, 100, 0, 0));
      send_pair(box_pair(10, 10, 0, 0, 0, 0, 50, 50, 0));
      send_pair(box_pair(0, 0, 10, 10, 100, 100, 10, 10, 0));
      send_pair(box_pair(0, 0, 10, 10, 10, 0, 10, 10, 0));
      send_pair(box_pair(0, 0, 10, 10, 0, 10, 10, 10, 1));
      send_pair(box_pair(10, 20, 30, 40, 10, 20, 30, 40, 2));
      send_pair(box_pair(-3, 7, 9, 4, -1, 6, 9, 4, 255));
      send_pair(box_pair(5, 5, 0, 0, 5, 5, 0, 0, 2));
      send_pair(box_pair(-20, -20, 30, 30, -5, -5, 30, 30, 0));
      send_pair(box_pair(-100, -100, 200, 200, -10, -10, 20, 20, 1));
      send_pair(box_pair(-32768, -32768, 65535, 65535, -32768, -32768, 65535, 65535, 0));
      send_pair(box_pair(32767, 32767, 65535, 65535, 32767, 32767, 65535, 65535, 0));
      send_pair(box_pair(-32768, -32768, 65535, 65535, 32767, 32767, 65535, 65535, 0));
      send_pair(box_pair(-32768, -32768, 65535, 65535, 32766, 32766, 65535, 65535, 0));
      send_pair(box_pair(-32768, 0, 65535, 1, 0, 0, 1, 1, 0));
      send_pair(box_pair(0, 0, 1, 1, 0, 0, 2, 1, 0));
      send_pair(box_pair(0, 0, 3, 1, 1, 0, 3, 1, 0));
      send_pair(box_pair(0, 0, 65535, 65535, 1, 1, 65535, 65535, 0));
      send_pair(box_pair(0, 0, 7, 9, 3, 4, 11, 2, 1));
      send_pair(box_pair(32767, -32768, 1, 1, 32767, -32768, 1, 1, 0));
   endtask

   task automatic test_overlapping_pairs(int count);
      pair_type p;
      int       span;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0:       span = 16;
            1:       span = 256;
            2:       span = 4096;
            default: span = 65535;
         endcase
         p = random_pair();
         p.track_width  = CB'($urandom_range(0, span));
         p.track_height = CB'($urandom_range(0, span));
         p.det_left = CB'(int'(p.track_left) + int'($urandom_range(0, span)) - span / 2);
         p.det_top  = CB'(int'(p.track_top) + int'($urandom_range(0, span)) - span / 2);
         if ($urandom_range(0, 1) == 0) begin
            p.det_width  = p.track_width;
            p.det_height = p.track_height;
         end else begin
            p.det_width  = CB'($urandom_range(0, span));
            p.det_height = CB'($urandom_range(0, span));
         end
         if ($urandom_range(0, 9) != 0)
            p.frames_stale = 8'($urandom_range(0, 1));
         send_pair(p);
      end
   endtask

   task automatic test_raw_pairs(int count);
      pair_type p;
      for (int i = 0; i < count; i++) begin
         p = random_pair();
         if ($urandom_range(0, 1) == 0)
            p.frames_stale = 8'($urandom_range(0, 1));
         send_pair(p);
      end
   endtask

   task automatic test_stale_tracks(int count);
      pair_type p;
      for (int i = 0; i < count; i++) begin
         p = random_pair();
         if ($urandom_range(0, 1) == 0) begin
            p.det_left   = p.track_left;
            p.det_top    = p.track_top;
            p.det_width  = p.track_width;
            p.det_height = p.track_height;
         end
         if ($urandom_range(0, 2) == 0)
            p.frames_stale = 8'($urandom_range(0, 3));
         send_pair(p);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      drive_payload(random_pair());
      burst_left = 8;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_corner_boxes();
      test_overlapping_pairs(380);
      test_raw_pairs(150);
      test_stale_tracks(50);

      req_chan.valid <= 1'b0;
      while (pending_costs.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("box_iou_cost verification clean");
      else
         $display("box_iou_cost verification failed");
      $finish;
   end

endmodule
